@@ sv/aflcs_pkg.sv @@
package aflcs_pkg;

  localparam int unsigned ScoreW = 16;
  localparam int unsigned CoefW  = 8;
  localparam int unsigned SymW   = 8;
  localparam int unsigned PosW   = 10;
  localparam int unsigned TbW    = 4;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned SumW   = ScoreW + 2;

  localparam logic signed [ScoreW-1:0] ScoreMin = {1'b1, {(ScoreW-1){1'b0}}};
  localparam logic signed [ScoreW-1:0] ScoreMax = {1'b0, {(ScoreW-1){1'b1}}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MATCH     = 4'd0,
    CFG_MISMATCH  = 4'd1,
    CFG_GAP_EXT   = 4'd2,
    CFG_GAP_OPEN  = 4'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIR_DIAG = 2'd0,
    DIR_UP   = 2'd1,
    DIR_LEFT = 2'd2
  } dir_e;

  typedef struct packed {
    logic signed [CoefW-1:0] match_score;
    logic signed [CoefW-1:0] mismatch_score;
    logic signed [CoefW-1:0] gap_extend;
    logic signed [CoefW-1:0] gap_open_extra;
  } cfg_t;

  typedef struct packed {
    logic [SymW-1:0]          query_sym;
    logic [SymW-1:0]          ref_sym;
    logic signed [ScoreW-1:0] up_match;
    logic signed [ScoreW-1:0] up_delete;
    logic signed [ScoreW-1:0] diag_match;
    logic signed [ScoreW-1:0] left_match;
    logic signed [ScoreW-1:0] left_insert;
    logic [PosW-1:0]          row;
    logic [PosW-1:0]          col;
    logic                     valid_req;
    logic                     new_alignment;
  } cell_req_t;

  typedef struct packed {
    logic signed [ScoreW-1:0] insert_score;
    logic signed [ScoreW-1:0] match_score_out;
    logic signed [ScoreW-1:0] delete_score;
    logic [TbW-1:0]           traceback;
    logic signed [ScoreW-1:0] best_score;
    logic [PosW-1:0]          best_row;
    logic [PosW-1:0]          best_col;
  } cell_rsp_t;

  typedef struct packed {
    logic signed [ScoreW-1:0] insert_score;
    logic signed [ScoreW-1:0] match_score_out;
    logic signed [ScoreW-1:0] delete_score;
    logic [TbW-1:0]           traceback;
  } cell_score_t;

  typedef struct packed {
    logic signed [ScoreW-1:0] score;
    logic [PosW-1:0]          row;
    logic [PosW-1:0]          col;
  } best_t;

  function automatic logic signed [ScoreW-1:0] sat_score(input logic signed [SumW-1:0] v);
    logic signed [ScoreW-1:0] r;
    if (v > $signed({{2{ScoreMax[ScoreW-1]}}, ScoreMax})) begin
      r = ScoreMax;
    end else if (v < $signed({{2{ScoreMin[ScoreW-1]}}, ScoreMin})) begin
      r = ScoreMin;
    end else begin
      r = v[ScoreW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SumW-1:0] ext_score(input logic signed [ScoreW-1:0] v);
    return {{(SumW-ScoreW){v[ScoreW-1]}}, v};
  endfunction

  function automatic logic signed [SumW-1:0] ext_coef(input logic signed [CoefW-1:0] v);
    return {{(SumW-CoefW){v[CoefW-1]}}, v};
  endfunction

endpackage

@@ sv/aflcs_cfg.sv @@
module aflcs_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [aflcs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [aflcs_pkg::CoefW-1:0]  cfg_data_i,
  output aflcs_pkg::cfg_t              cfg_o
);

  aflcs_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        aflcs_pkg::CFG_MATCH:    cfg_d.match_score    = cfg_data_i;
        aflcs_pkg::CFG_MISMATCH: cfg_d.mismatch_score = cfg_data_i;
        aflcs_pkg::CFG_GAP_EXT:  cfg_d.gap_extend     = cfg_data_i;
        aflcs_pkg::CFG_GAP_OPEN: cfg_d.gap_open_extra = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_score    <= 8'sd1;
      cfg_q.mismatch_score <= -8'sd1;
      cfg_q.gap_extend     <= -8'sd1;
      cfg_q.gap_open_extra <= -8'sd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/aflcs_cell.sv @@
module aflcs_cell (
  input  aflcs_pkg::cfg_t        cfg_i,
  input  aflcs_pkg::cell_req_t   req_i,
  output aflcs_pkg::cell_score_t score_o
);

  logic signed [aflcs_pkg::SumW-1:0]   open_cost, ext_cost, sub_cost;
  logic signed [aflcs_pkg::ScoreW-1:0] ins_open, ins_ext, del_open, del_ext;
  logic signed [aflcs_pkg::ScoreW-1:0] ins, del, diag, best;
  logic                                ins_opened, del_opened;
  aflcs_pkg::dir_e                     dir;

  always_comb begin
    open_cost = aflcs_pkg::ext_coef(cfg_i.gap_extend) + aflcs_pkg::ext_coef(cfg_i.gap_open_extra);
    ext_cost  = aflcs_pkg::ext_coef(cfg_i.gap_extend);
    sub_cost  = (req_i.query_sym == req_i.ref_sym) ? aflcs_pkg::ext_coef(cfg_i.match_score)
                                                   : aflcs_pkg::ext_coef(cfg_i.mismatch_score);

    ins_open = aflcs_pkg::sat_score(aflcs_pkg::ext_score(req_i.left_match) + open_cost);
    ins_ext  = aflcs_pkg::sat_score(aflcs_pkg::ext_score(req_i.left_insert) + ext_cost);
    del_open = aflcs_pkg::sat_score(aflcs_pkg::ext_score(req_i.up_match) + open_cost);
    del_ext  = aflcs_pkg::sat_score(aflcs_pkg::ext_score(req_i.up_delete) + ext_cost);
    diag     = aflcs_pkg::sat_score(aflcs_pkg::ext_score(req_i.diag_match) + sub_cost);

    ins_opened = ins_open > ins_ext;
    del_opened = del_open > del_ext;
    ins = ins_opened ? ins_open : ins_ext;
    del = del_opened ? del_open : del_ext;

    best = (ins > del) ? ins : del;
    if (diag > best) begin
      best = diag;
    end

    priority if (best == ins) begin
      dir = aflcs_pkg::DIR_LEFT;
    end else if (best == del) begin
      dir = aflcs_pkg::DIR_UP;
    end else begin
      dir = aflcs_pkg::DIR_DIAG;
    end

    score_o.insert_score    = ins;
    score_o.match_score_out = best;
    score_o.delete_score    = del;
    score_o.traceback       = {!del_opened, !ins_opened, dir};
  end

endmodule

@@ sv/aflcs_best.sv @@
module aflcs_best (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  logic                               clear_i,
  input  logic                               valid_req_i,
  input  logic signed [aflcs_pkg::ScoreW-1:0] score_i,
  input  logic [aflcs_pkg::PosW-1:0]         row_i,
  input  logic [aflcs_pkg::PosW-1:0]         col_i,
  output aflcs_pkg::best_t                   best_d_o,
  output aflcs_pkg::best_t                   best_q_o
);

  aflcs_pkg::best_t best_q, base, best_d;

  always_comb begin
    if (clear_i) begin
      base.score = aflcs_pkg::ScoreMin;
      base.row   = '0;
      base.col   = '0;
    end else begin
      base = best_q;
    end
    best_d = base;
    if (valid_req_i && (score_i > base.score)) begin
      best_d.score = score_i;
      best_d.row   = row_i;
      best_d.col   = col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q.score <= aflcs_pkg::ScoreMin;
      best_q.row   <= '0;
      best_q.col   <= '0;
    end else if (load_i) begin
      best_q <= best_d;
    end
  end

  assign best_d_o = best_d;
  assign best_q_o = best_q;

endmodule

@@ sv/affine_local_cell_scorer.sv @@
// Channel | Direction | Handshake             | Payload
// in      | request   | in_valid_i/in_stall_o   | in_req_i (cell_req_t)
// out     | result    | out_valid_o/out_stall_i | out_rsp_o (cell_rsp_t)
// cfg     | write     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// A request is registered on acceptance and its result is written to the result register
// when it advances; one request is taken every cycle while the output is not stalled.
// The scoring and the best-score update sit between the input and result registers.
// Reset loads the default scoring registers and clears the best-score record.
// A stalled result holds both registers; the input side stalls only when both are full.
module affine_local_cell_scorer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  aflcs_pkg::cell_req_t          in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output aflcs_pkg::cell_rsp_t          out_rsp_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [aflcs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [aflcs_pkg::CoefW-1:0]   cfg_data_i
);

  aflcs_pkg::cfg_t        cfg;
  aflcs_pkg::cell_req_t   req_q;
  aflcs_pkg::cell_rsp_t   rsp_q, rsp_d;
  aflcs_pkg::cell_score_t score;
  aflcs_pkg::best_t       best_d, best_q;
  logic                   req_vld_q, rsp_vld_q;
  logic                   out_free, advance, in_take;

  assign out_free   = !rsp_vld_q || !out_stall_i;
  assign advance    = req_vld_q && out_free;
  assign in_stall_o = req_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  aflcs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  aflcs_cell u_cell (
    .cfg_i  (cfg),
    .req_i  (req_q),
    .score_o(score)
  );

  aflcs_best u_best (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .clear_i    (req_q.new_alignment),
    .valid_req_i(req_q.valid_req),
    .score_i    (score.match_score_out),
    .row_i      (req_q.row),
    .col_i      (req_q.col),
    .best_d_o   (best_d),
    .best_q_o   (best_q)
  );

  always_comb begin
    rsp_d.insert_score    = score.insert_score;
    rsp_d.match_score_out = score.match_score_out;
    rsp_d.delete_score    = score.delete_score;
    rsp_d.traceback       = score.traceback;
    rsp_d.best_score      = best_d.score;
    rsp_d.best_row        = best_d.row;
    rsp_d.best_col        = best_d.col;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        req_vld_q <= 1'b1;
      end else if (advance) begin
        req_vld_q <= 1'b0;
      end
      if (out_free) begin
        rsp_vld_q <= req_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q <= in_req_i;
    end
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = rsp_vld_q;
  assign out_rsp_o   = rsp_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (req_vld_q && rsp_vld_q && out_stall_i))
    else $error("input stalled while a register stage was free");

  a_record_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !req_q.new_alignment) |=> (best_q.score >= $past(best_q.score)))
    else $error("best score decreased without a new alignment");

  a_match_is_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_rsp_o.match_score_out >= out_rsp_o.insert_score) &&
                     (out_rsp_o.match_score_out >= out_rsp_o.delete_score)))
    else $error("match layer score below a gap layer score");

  a_tb_dir_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.traceback[1:0] != 2'b11))
    else $error("illegal traceback direction");

endmodule
